@@ sv/dsc_pkg.sv @@
// Shared types and codes for the dedup collect-and-sort block.
package dsc_pkg;

    localparam int unsigned VAL_W  = 32;
    localparam int unsigned KIND_W = 3;

    localparam logic [KIND_W-1:0] KIND_ACCEPT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DUP    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FULL   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ELEM   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EMPTY  = 3'd4;

    typedef logic signed [VAL_W-1:0] t_val;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_DRAIN,
        ST_EMPTY
    } t_state;

    typedef struct packed {
        logic ins;
        logic shift;
    } t_cell_ctl;

endpackage

@@ sv/dsc_cell.sv @@
// One cell of the sorted chain: holds one value, inserts or shifts towards the head.
module dsc_cell
    import dsc_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_val      i_new,
    input  logic      i_occ,
    input  t_val      i_left_val,
    input  logic      i_left_open,
    input  t_val      i_right_val,
    output t_val      o_val,
    output logic      o_open,
    output logic      o_eq
);

    t_val r_val;
    t_val n_val;

    // open: this slot and all after it move up by one on an insert
    assign o_open = !i_occ || (r_val > i_new);
    assign o_eq   = i_occ && (r_val == i_new);
    assign o_val  = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.shift) begin
            n_val = i_right_val;
        end else if (i_ctl.ins && o_open) begin
            n_val = i_left_open ? i_left_val : i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

@@ sv/dedup_collect_and_sort.sv @@
// Top level: collects distinct nonzero values in a sorted cell chain, drains on zero.
//
//  channel   ports                              direction  beat when
//  command   start, busy, i_value               in         start && !busy
//  result    o_strobe, o_kind, o_value_res,     out        o_strobe
//            o_last
//
// A nonzero value is captured, then compared against every cell and inserted unless it is a
// duplicate or the chain is full. A zero value drains all N values, N the held count;
// the chain shifts one element a cycle to the head, so results come out in ascending order.
// Reset (synchronous, active low) empties the chain by clearing the count.
// The receiver cannot stall; each result stands for one cycle only.
module dedup_collect_and_sort
    import dsc_pkg::*;
#(
    parameter int unsigned CAPACITY = 32
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_strobe,
    output logic [KIND_W-1:0]       o_kind,
    output logic signed [VAL_W-1:0] o_value_res,
    output logic                    o_last
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    t_val              r_in;
    logic              r_strobe, n_strobe;
    logic [KIND_W-1:0] r_kind, n_kind;
    t_val              r_res, n_res;
    logic              r_last, n_last;
    t_cell_ctl         ctl;

    t_val              cell_val  [CAPACITY];
    logic              cell_open [CAPACITY];
    logic [CAPACITY-1:0] cell_eq;
    logic [CAPACITY-1:0] occ;

    logic accept;
    logic dup;
    logic full;

    assign busy   = (r_state != ST_IDLE) || !i_rst_n;
    assign accept = start && !busy;
    assign dup    = |cell_eq;
    assign full   = (r_count == CW'(CAPACITY));

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_val left_val;
            logic left_open;
            t_val right_val;

            assign occ[g] = (CW'(g) < r_count);

            if (g == 0) begin : g_head
                assign left_val  = r_in;
                assign left_open = 1'b0;
            end else begin : g_mid
                assign left_val  = cell_val[g-1];
                assign left_open = cell_open[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign right_val = r_in;
            end else begin : g_body
                assign right_val = cell_val[g+1];
            end

            dsc_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_new       (r_in),
                .i_occ       (occ[g]),
                .i_left_val  (left_val),
                .i_left_open (left_open),
                .i_right_val (right_val),
                .o_val       (cell_val[g]),
                .o_open      (cell_open[g]),
                .o_eq        (cell_eq[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_value;
        end
        r_kind <= n_kind;
        r_res  <= n_res;
        r_last <= n_last;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_strobe  = 1'b0;
        n_kind    = r_kind;
        n_res     = r_res;
        n_last    = r_last;
        ctl.ins   = 1'b0;
        ctl.shift = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_value != '0) begin
                        n_state = ST_INSERT;
                    end else if (r_count == '0) begin
                        n_state = ST_EMPTY;
                    end else begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_INSERT: begin
                n_strobe = 1'b1;
                n_res    = r_in;
                n_last   = 1'b1;
                if (dup) begin
                    n_kind = KIND_DUP;
                end else if (full) begin
                    n_kind = KIND_FULL;
                end else begin
                    n_kind  = KIND_ACCEPT;
                    ctl.ins = 1'b1;
                    n_count = r_count + CW'(1);
                end
                n_state = ST_IDLE;
            end
            ST_DRAIN: begin
                n_strobe  = 1'b1;
                n_kind    = KIND_ELEM;
                n_res     = cell_val[0];
                n_last    = (r_count == CW'(1));
                ctl.shift = 1'b1;
                n_count   = r_count - CW'(1);
                if (r_count == CW'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMPTY: begin
                n_strobe = 1'b1;
                n_kind   = KIND_EMPTY;
                n_res    = '0;
                n_last   = 1'b1;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_strobe    = r_strobe;
    assign o_kind      = r_kind;
    assign o_value_res = r_res;
    assign o_last      = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("held count beyond capacity");

    a_status_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_value != '0)) |=> ##1 o_strobe)
        else $error("no status beat two cycles after a nonzero value");

    a_drain_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_kind == KIND_ELEM) && o_last) |-> (r_count == '0))
        else $error("chain not empty after last sorted beat");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_kind != KIND_ELEM)) |-> o_last)
        else $error("status beat without last");

endmodule
